// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/mbbp_pkg.sv
`timescale 1ns / 1ps
package mbbp_pkg;
    localparam int CHANNELS_DEF       = 8;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 30;
    localparam int CH_BITS            = 3;
    localparam int CFG_IDX_BITS       = 3;
    localparam int CFG_DATA_BITS      = 32;
    localparam int W                  = 48;
    localparam int DIGIT              = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HP_GAIN = 3'd0,
        REG_HP_A1   = 3'd1,
        REG_HP_A2   = 3'd2,
        REG_LP_GAIN = 3'd3,
        REG_LP_A1   = 3'd4,
        REG_LP_A2   = 3'd5,
        REG_BYPASS  = 3'd6
    } t_reg_idx;
endpackage

// File: rtl/core/mbbp_stream_if.sv
`timescale 1ns / 1ps
interface mbbp_stream_if #(
    parameter int DATA_BITS = 24
) ();
    import mbbp_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [CH_BITS-1:0]          channel;
    logic signed [DATA_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

// File: rtl/core/multichannel_biquad_bandpass.sv
`timescale 1ns / 1ps
// In bypass the sample goes straight to the result register; when filtering it
// passes through both sections and a rounding state. Throughput: one transaction
// at a time; the next is taken once the sequencer is idle and the result register
// is free. Each multiply has a launch state and a wait state on the digit-serial
// multiplier, which consumes four bits of the 52-bit signal operand per cycle;
// each section adds a RAM read and an update state, and rounding adds one more.
// Reset (synchronous, active low) clears control, coefficients (bypass = 1)
// and all delay words through per-channel valid bits.
module multichannel_biquad_bandpass #(
    parameter int CHANNELS       = mbbp_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS    = mbbp_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = mbbp_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbbp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mbbp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    mbbp_stream_if.sink                        s_in,
    mbbp_stream_if.source                      m_out
);
    import mbbp_pkg::*;
    localparam int FRAC_D = 44 - SAMPLE_BITS;
    localparam int CIB    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [51:0] WMAX = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [51:0] WMIN = -52'sh0_8000_0000_0000;

    // Sequencer states: one multiply per step, two sections in a row.
    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_P_GO, ST_P_WAIT, ST_A1_GO, ST_A1_WAIT,
        ST_A2_GO, ST_A2_WAIT, ST_UPD, ST_ROUND
    } t_state;

    // Configuration registers.
    logic [30:0] r_hp_gain, r_lp_gain;
    logic signed [31:0] r_hp_a1, r_hp_a2, r_lp_a1, r_lp_a2;
    logic r_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_gain <= '0; r_lp_gain <= '0;
            r_hp_a1 <= '0; r_hp_a2 <= '0; r_lp_a1 <= '0; r_lp_a2 <= '0;
            r_bypass <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_HP_GAIN: r_hp_gain <= i_cfg_data[30:0];
                REG_HP_A1:   r_hp_a1   <= i_cfg_data;
                REG_HP_A2:   r_hp_a2   <= i_cfg_data;
                REG_LP_GAIN: r_lp_gain <= i_cfg_data[30:0];
                REG_LP_A1:   r_lp_a1   <= i_cfg_data;
                REG_LP_A2:   r_lp_a2   <= i_cfg_data;
                REG_BYPASS:  r_bypass  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Per-channel delay memories: one RAM per section, both words per entry.
    // A valid bit per channel makes a never-written entry read as zero.
    logic r_state_sec;  // 0: high-pass, 1: low-pass
    logic [CIB-1:0] r_ch_idx;
    logic r_we;
    logic [95:0] r_wdata;
    logic [95:0] w_hp_rd, w_lp_rd;
    logic [CHANNELS-1:0] r_hp_vld, r_lp_vld;

    mbbp_ram #(.WIDTH(96), .DEPTH(1 << CIB)) u_hp_ram (
        .i_clk(i_clk), .i_we(r_we && !r_state_sec), .i_waddr(r_ch_idx),
        .i_wdata(r_wdata), .i_raddr(r_ch_idx), .o_rdata(w_hp_rd));
    mbbp_ram #(.WIDTH(96), .DEPTH(1 << CIB)) u_lp_ram (
        .i_clk(i_clk), .i_we(r_we && r_state_sec), .i_waddr(r_ch_idx),
        .i_wdata(r_wdata), .i_raddr(r_ch_idx), .o_rdata(w_lp_rd));

    // Shared multiplier.
    logic r_mstart;
    logic signed [50:0] r_ma;
    logic signed [31:0] r_mc;
    logic w_mdone;
    logic signed [51:0] w_mp;

    mbbp_mulc #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart), .i_a(r_ma),
        .i_c(r_mc), .o_done(w_mdone), .o_p(w_mp));

    function automatic logic signed [51:0] sat48(input logic signed [53:0] v);
        if (v > 54'(WMAX)) return WMAX;
        if (v < 54'(WMIN)) return WMIN;
        return 52'(v);
    endfunction

    t_state r_st;
    logic [CH_BITS-1:0] r_ch;
    logic signed [51:0] r_x, r_p, r_y, r_ta1, r_d1, r_d2;
    logic r_ovalid;
    logic [CH_BITS-1:0] r_och;
    logic signed [SAMPLE_BITS-1:0] r_osmp;

    logic w_take;
    logic signed [53:0] w_n1, w_n2;
    logic signed [52:0] w_rnd;
    logic signed [52:0] w_q;
    logic w_vld;

    assign w_take = s_in.valid && s_in.ready;
    assign s_in.ready = (r_st == ST_IDLE) && !r_ovalid;
    assign w_vld = r_state_sec ? r_lp_vld[r_ch_idx] : r_hp_vld[r_ch_idx];
    assign w_n1 = (r_state_sec ? 54'(r_p) * 2 : -(54'(r_p) * 2)) - 54'(w_mp) + 54'(r_d2);
    assign w_n2 = 54'(r_p) - 54'(w_mp);
    assign w_rnd = 53'(r_y) + 53'(53'sd1 <<< (FRAC_D - 1));
    assign w_q = w_rnd >>> FRAC_D;

    always_ff @(posedge i_clk) begin
        r_mstart <= 1'b0;
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ovalid <= 1'b0;
            r_hp_vld <= '0; r_lp_vld <= '0; r_state_sec <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (w_take) begin
                        r_ch <= s_in.channel;
                        r_ch_idx <= CIB'(s_in.channel);
                        r_state_sec <= 1'b0;
                        r_x <= 52'(s_in.sample) <<< FRAC_D;
                        if (r_bypass || 32'(s_in.channel) >= CHANNELS) begin
                            r_och <= s_in.channel; r_osmp <= s_in.sample;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_st <= ST_READ;
                        end
                    end
                end
                ST_READ: r_st <= ST_P_GO;  // RAM read settles
                ST_P_GO: begin
                    r_d1 <= w_vld ? 52'(signed'(r_state_sec ? w_lp_rd[47:0] : w_hp_rd[47:0])) : '0;
                    r_d2 <= w_vld ? 52'(signed'(r_state_sec ? w_lp_rd[95:48] : w_hp_rd[95:48])) : '0;
                    r_ma <= 51'(r_x);
                    r_mc <= 32'({1'b0, r_state_sec ? r_lp_gain : r_hp_gain});
                    r_mstart <= 1'b1;
                    r_st <= ST_P_WAIT;
                end
                ST_P_WAIT: if (w_mdone) begin
                    r_p <= w_mp;
                    r_y <= sat48(54'(w_mp) + 54'(r_d1));
                    r_st <= ST_A1_GO;
                end
                ST_A1_GO: begin
                    r_ma <= 51'(r_y);
                    r_mc <= r_state_sec ? r_lp_a1 : r_hp_a1;
                    r_mstart <= 1'b1;
                    r_st <= ST_A1_WAIT;
                end
                ST_A1_WAIT: if (w_mdone) begin
                    r_ta1 <= sat48(w_n1);
                    r_st <= ST_A2_GO;
                end
                ST_A2_GO: begin
                    r_mc <= r_state_sec ? r_lp_a2 : r_hp_a2;
                    r_mstart <= 1'b1;
                    r_st <= ST_A2_WAIT;
                end
                ST_A2_WAIT: if (w_mdone) begin
                    r_wdata <= {48'(sat48(w_n2)), 48'(r_ta1)};
                    r_we <= 1'b1;
                    r_st <= ST_UPD;
                end
                ST_UPD: begin
                    if (r_state_sec) r_lp_vld[r_ch_idx] <= 1'b1;
                    else r_hp_vld[r_ch_idx] <= 1'b1;
                    if (!r_state_sec) begin
                        r_state_sec <= 1'b1;
                        r_x <= r_y;
                        r_st <= ST_READ;
                    end else begin
                        r_st <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_och <= r_ch;
                    if (w_q > 53'((53'sd1 <<< (SAMPLE_BITS - 1)) - 1))
                        r_osmp <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    else if (w_q < -(53'sd1 <<< (SAMPLE_BITS - 1)))
                        r_osmp <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    else
                        r_osmp <= SAMPLE_BITS'(w_q);
                    r_ovalid <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_out.valid   = r_ovalid;
    assign m_out.channel = r_och;
    assign m_out.sample  = r_osmp;
endmodule

// File: rtl/core/mbbp_ram.sv
`timescale 1ns / 1ps
module mbbp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/mbbp_mulc.sv
`timescale 1ns / 1ps
// Digit-serial signed multiply: |a| * |c| accumulated four bits of the
// signal operand per cycle, then shifted down by the fraction width,
// truncated toward zero and clamped to magnitude 2^50.
module mbbp_mulc #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [50:0]  i_a,
    input  logic signed [31:0]  i_c,
    output logic                o_done,
    output logic signed [51:0]  o_p
);
    import mbbp_pkg::*;
    localparam int STEPS = 52 / DIGIT;

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic [51:0] r_a, n_a;
    logic [31:0] r_c, n_c;
    logic [83:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [51:0] r_p, n_p;
    logic [83:0] w_shift;
    logic [51:0] w_mag;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_a = r_a; n_c = r_c;
        n_acc = r_acc; n_neg = r_neg; n_done = 1'b0; n_p = r_p;
        w_shift = r_acc >> COEF_FRAC_BITS;
        w_mag = (w_shift > 84'(52'd1 << 50)) ? (52'd1 << 50) : w_shift[51:0];
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a[50] ? 52'(-{i_a[50], i_a}) : 52'({i_a[50], i_a});
            n_c    = i_c[31] ? 32'(-i_c) : i_c;
            n_neg  = i_a[50] ^ i_c[31];
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = (r_acc << DIGIT) + 84'(r_a[51 -: DIGIT] * r_c);
            n_a   = r_a << DIGIT;
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(STEPS)) begin
                n_acc  = r_acc;
                n_busy = 1'b0;
                n_done = 1'b1;
                n_p    = r_neg ? 52'(-w_mag) : w_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_a <= n_a; r_c <= n_c; r_acc <= n_acc; r_neg <= n_neg; r_p <= n_p;
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

// File: rtl/core/mbbp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbbp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_IMPL(a_no_take_when_full, i_clk, i_rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule

bind multichannel_biquad_bandpass mbbp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready));
